### sv/csbh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package csbh_pkg;

  localparam int unsigned HASH_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [HASH_W-1:0] HASH_START    = 32'hAED0_2019;
  localparam logic [HASH_W-1:0] HASH_POLY     = 32'hAED0_011F;
  localparam logic [HASH_W-1:0] RESET_BUCKETS = 32'd1024;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } hash_push_t;

  // Reflected CRC table entry for one byte value.
  function automatic logic [HASH_W-1:0] crc_entry(input logic [BYTE_W-1:0] idx);
    logic [HASH_W-1:0] v;
    v = {{(HASH_W-BYTE_W){1'b0}}, idx};
    for (int k = 0; k < BYTE_W; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ HASH_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  function automatic logic [HASH_W-1:0] crc_step(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    return (h >> BYTE_W) ^ crc_entry(h[BYTE_W-1:0]) ^ {b, {(HASH_W-BYTE_W){1'b0}}};
  endfunction

endpackage
`default_nettype wire

### sv/csbh_front.sv
`timescale 1ns / 1ps
`default_nettype none
module csbh_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [csbh_pkg::BYTE_W-1:0]   key_byte_i,
  input  wire logic                          carries_byte_i,
  input  wire logic                          end_of_key_i,
  input  wire logic                          queue_full_i,
  output csbh_pkg::hash_push_t               push_o
);

  logic [csbh_pkg::HASH_W-1:0] hash_q, hash_d, hash_upd;
  logic                        accept;

  assign in_ready_o = ~queue_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign hash_upd   = carries_byte_i ? csbh_pkg::crc_step(hash_q, key_byte_i) : hash_q;

  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      hash_d = end_of_key_i ? csbh_pkg::HASH_START : hash_upd;
    end
  end

  assign push_o.valid = accept & end_of_key_i;
  assign push_o.hash  = hash_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= csbh_pkg::HASH_START;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule
`default_nettype wire

### sv/csbh_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module csbh_queue #(
  parameter int unsigned Depth = csbh_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire csbh_pkg::hash_push_t          push_i,
  output logic                               full_o,
  output logic                               valid_o,
  output logic [csbh_pkg::HASH_W-1:0]        hash_o,
  input  wire logic                          pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [csbh_pkg::HASH_W-1:0] mem_q [Depth];
  logic [PtrW-1:0]             wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign hash_o  = mem_q[rd_q];
  assign do_push = push_i.valid & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

### sv/csbh_back.sv
`timescale 1ns / 1ps
`default_nettype none
module csbh_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [csbh_pkg::HASH_W-1:0]   cfg_wdata_i,
  input  wire logic                          q_valid_i,
  input  wire logic [csbh_pkg::HASH_W-1:0]   q_hash_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [csbh_pkg::HASH_W-1:0]        bucket_index_o,
  output logic [csbh_pkg::HASH_W-1:0]        raw_hash_o
);

  localparam int unsigned W    = csbh_pkg::HASH_W;
  localparam int unsigned CntW = $clog2(W);
  localparam logic [CntW-1:0] LastStep = CntW'(W - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  state_e         state_q, state_d;
  logic [W-1:0]   bucket_q, bucket_d;
  logic [W-1:0]   dvd_q, dvd_d;
  logic [W-1:0]   rem_q, rem_d;
  logic [W-1:0]   raw_q, raw_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic           out_valid_q, out_valid_d;
  logic [W-1:0]   out_idx_q, out_idx_d;
  logic [W-1:0]   out_raw_q, out_raw_d;
  logic [W:0]     rem_sh, rem_nx;
  logic           out_free;

  assign out_free = ~out_valid_q | out_ready_i;
  assign rem_sh   = {rem_q, dvd_q[W-1]};
  assign rem_nx   = (rem_sh >= {1'b0, bucket_q}) ? rem_sh - {1'b0, bucket_q} : rem_sh;
  assign bucket_d = cfg_we_i ? cfg_wdata_i : bucket_q;

  always_comb begin
    state_d     = state_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    raw_d       = raw_q;
    cnt_d       = cnt_q;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_idx_d   = out_idx_q;
    out_raw_d   = out_raw_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          dvd_d   = q_hash_i;
          raw_d   = q_hash_i;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = rem_nx[W-1:0];
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_idx_d   = rem_nx[W-1:0];
            out_raw_d   = raw_q;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = rem_q;
          out_raw_d   = raw_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign bucket_index_o = out_idx_q;
  assign raw_hash_o     = out_raw_q;

  always_ff @(posedge clk_i) begin
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    raw_q     <= raw_d;
    out_idx_q <= out_idx_d;
    out_raw_q <= out_raw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bucket_q    <= csbh_pkg::RESET_BUCKETS;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bucket_q    <= bucket_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

### sv/crc_string_bucket_hash_top.sv
// String hash with bucket reduction.
// Key bytes enter on the input channel (valid/ready), one per transaction;
// carries_byte_i marks a byte to hash and end_of_key_i closes the key. A
// closing transaction with no byte ends the key on the bytes taken before it.
// The front end hashes one byte per cycle while in_ready_o is high, with a
// table-driven CRC step. On the closing transaction the hash goes into a
// short queue and the running hash reloads its start value.
// The back end reduces each queued hash modulo the bucket count with a
// bit-serial remainder unit of 32 steps, and takes the next hash from the
// queue only once the last result has gone into the output register. Keys
// keep streaming into the queue meanwhile.
// The user must write the bucket count through cfg_we_i/cfg_wdata_i only
// while no key is in flight; the block itself does not enforce this. A
// count of zero returns the raw hash as the index.
// Reset clears the queue and the output valid flag, loads the start hash and
// sets the bucket count to 1024. When the receiver stalls, the result holds
// in the output register; once the queue also fills, in_ready_o falls.
`timescale 1ns / 1ps
`default_nettype none
module crc_string_bucket_hash_top #(
  parameter int unsigned QueueDepth = csbh_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [csbh_pkg::BYTE_W-1:0]   key_byte_i,
  input  wire logic                          carries_byte_i,
  input  wire logic                          end_of_key_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [csbh_pkg::HASH_W-1:0]        bucket_index_o,
  output logic [csbh_pkg::HASH_W-1:0]        raw_hash_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [csbh_pkg::HASH_W-1:0]   cfg_wdata_i
);

  csbh_pkg::hash_push_t        push;
  logic                        q_full, q_valid, q_pop;
  logic [csbh_pkg::HASH_W-1:0] q_hash;

  csbh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .key_byte_i     (key_byte_i),
    .carries_byte_i (carries_byte_i),
    .end_of_key_i   (end_of_key_i),
    .queue_full_i   (q_full),
    .push_o         (push)
  );

  csbh_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .hash_o  (q_hash),
    .pop_i   (q_pop)
  );

  csbh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_valid_i      (q_valid),
    .q_hash_i       (q_hash),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bucket_index_o (bucket_index_o),
    .raw_hash_o     (raw_hash_o)
  );

endmodule
`default_nettype wire

### tb/crc_string_bucket_hash_top_tb.sv
`timescale 1ns / 1ps
module crc_string_bucket_hash_top_tb;

  typedef struct packed {
    logic [csbh_pkg::HASH_W-1:0] bucket_index;
    logic [csbh_pkg::HASH_W-1:0] raw_hash;
  } bucket_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [csbh_pkg::BYTE_W-1:0] key_byte_i;
  logic                        carries_byte_i;
  logic                        end_of_key_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [csbh_pkg::HASH_W-1:0] bucket_index_o;
  logic [csbh_pkg::HASH_W-1:0] raw_hash_o;
  logic                        cfg_we_i;
  logic [csbh_pkg::HASH_W-1:0] cfg_wdata_i;

  logic [csbh_pkg::HASH_W-1:0] crc_lut [256];
  logic [csbh_pkg::HASH_W-1:0] key_hash;
  logic [csbh_pkg::HASH_W-1:0] bucket_modulus;
  bucket_result_t              pending_buckets[$];
  bit                          failed;
  bit                          tx_idle_on;
  bit                          rx_idle_on;
  int                          hold_requests;

  crc_string_bucket_hash_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .key_byte_i     (key_byte_i),
    .carries_byte_i (carries_byte_i),
    .end_of_key_i   (end_of_key_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bucket_index_o (bucket_index_o),
    .raw_hash_o     (raw_hash_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 800000);
    $display("Some tests failed");
    $finish;
  end

  function automatic void build_crc_lut();
    logic [csbh_pkg::HASH_W-1:0] v;
    for (int i = 0; i < 256; i++) begin
      v = csbh_pkg::HASH_W'(i);
      for (int k = 0; k < 8; k++) begin
        if (v[0]) begin
          v = (v >> 1) ^ csbh_pkg::HASH_POLY;
        end else begin
          v = v >> 1;
        end
      end
      crc_lut[i] = v;
    end
  endfunction

  // Advances the key hash for one accepted transaction and queues the
  // bucket result that a closing transaction produces.
  function automatic void hash_key_item(input logic [csbh_pkg::BYTE_W-1:0] b, input logic cb,
                                        input logic eok);
    bucket_result_t res;
    if (cb) begin
      key_hash = (key_hash >> 8) ^ crc_lut[key_hash[7:0]] ^ {b, 24'h000000};
    end
    if (eok) begin
      res.raw_hash     = key_hash;
      res.bucket_index = (bucket_modulus != 0) ? key_hash % bucket_modulus : key_hash;
      pending_buckets.push_back(res);
      key_hash = csbh_pkg::HASH_START;
    end
  endfunction

  task automatic send_item(input logic [csbh_pkg::BYTE_W-1:0] b, input logic cb,
                           input logic eok);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    key_byte_i     <= b;
    carries_byte_i <= cb;
    end_of_key_i   <= eok;
    do @(posedge clk_i); while (!in_ready_o);
    hash_key_item(b, cb, eok);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_buckets.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_bucket_count(input logic [csbh_pkg::HASH_W-1:0] n);
    drain_results();
    cfg_wdata_i <= n;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    bucket_modulus  = n;
  endtask

  // Random keys, mostly short, some long, with stray empty transactions and
  // keys that are closed by a separate transaction without a byte.
  task automatic send_random_keys(input int target);
    int  done_items;
    int  len;
    bit  closed;
    done_items = 0;
    while (done_items < target) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 5);
      closed = 1'b0;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_item(csbh_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        closed = (k == len - 1) && ($urandom_range(0, 3) != 0);
        send_item(csbh_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1, closed);
        done_items++;
      end
      if (!closed) begin
        send_item(csbh_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        done_items++;
      end
    end
  endtask

  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    send_item(8'hA5, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h33, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'hFE, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    drain_results();
  endtask

  task automatic test_bucket_extremes();
    logic [csbh_pkg::HASH_W-1:0] counts [6];
    counts = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd2, 32'hFFFF_FFFE};
    foreach (counts[i]) begin
      set_bucket_count(counts[i]);
      send_item(8'h00, 1'b0, 1'b1);
      send_random_keys(8);
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [csbh_pkg::HASH_W-1:0] counts [9];
    counts = '{csbh_pkg::RESET_BUCKETS, 32'd0, 32'd1, 32'd3, 32'hFFFF_FFFF, 32'd1000,
               $urandom, $urandom_range(1, 100), 32'h0001_0000};
    foreach (counts[i]) begin
      tx_idle_on = (i % 3 != 1);
      rx_idle_on = (i % 4 != 2);
      set_bucket_count(counts[i]);
      send_random_keys(130);
    end
    drain_results();
  endtask

  // The sink stops taking results for a long stretch while keys keep
  // arriving, so the queue fills and the input channel stalls.
  task automatic test_back_pressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_bucket_count(32'd777);
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 24; i++) begin
      send_item(csbh_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
    drain_results();
  endtask

  initial begin : result_sink
    int             stall_left;
    int             hold_left;
    int             holds_taken;
    bucket_result_t want;
    stall_left  = 0;
    hold_left   = 0;
    holds_taken = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_buckets.size() == 0) begin
          $display("%0t: result transaction with none expected: index %h hash %h",
                   $time, bucket_index_o, raw_hash_o);
          failed = 1'b1;
        end else begin
          want = pending_buckets.pop_front();
          if (bucket_index_o !== want.bucket_index) begin
            $display("%0t: bucket_index expected %h, actual %h",
                     $time, want.bucket_index, bucket_index_o);
            failed = 1'b1;
          end
          if (raw_hash_o !== want.raw_hash) begin
            $display("%0t: raw_hash expected %h, actual %h", $time, want.raw_hash, raw_hash_o);
            failed = 1'b1;
          end
        end
        stall_left = rx_idle_on ? $urandom_range(0, 17) : 0;
      end
      if (holds_taken != hold_requests) begin
        holds_taken = hold_requests;
        hold_left   = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    key_byte_i     <= '0;
    carries_byte_i <= 1'b0;
    end_of_key_i   <= 1'b0;
    out_ready_i    <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    hold_requests  <= 0;
    failed          = 1'b0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    build_crc_lut();
    key_hash       = csbh_pkg::HASH_START;
    bucket_modulus = csbh_pkg::RESET_BUCKETS;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_bucket_extremes();
    test_random_traffic();
    test_back_pressure();

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
